/* hw/rtl/isqrt_pkg.sv */
// Shared constants and request codes for the integer square root unit.
package isqrt_pkg;

	// Default radicand width handed to the top level.
	localparam int ISQRT_OPERAND_WIDTH = 64;

	// Fixed payload widths of the request and response channels.
	localparam int OPERAND_W  = 64;
	localparam int REQ_TYPE_W = 2;
	localparam int ROOT_W     = 64;
	localparam int FRAC_W     = 6;

	// Request type codes; every other code selects the normalized root.
	localparam logic [REQ_TYPE_W-1:0] REQ_INT    = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_SCALED = 2'd1;

endpackage

/* hw/rtl/isqrt_req_if.sv */
// Request channel of the square root unit: operand and request type.
interface isqrt_req_if import isqrt_pkg::*; ();

	logic                  valid;
	logic                  ready;
	logic [OPERAND_W-1:0]  operand;
	logic [REQ_TYPE_W-1:0] req_type;

	modport source (output valid, output operand, output req_type, input ready);
	modport sink (input valid, input operand, input req_type, output ready);

endinterface

/* hw/rtl/isqrt_rsp_if.sv */
// Response channel of the square root unit: root and fraction-bit count.
interface isqrt_rsp_if import isqrt_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [ROOT_W-1:0] root;
	logic [FRAC_W-1:0] frac_bits;

	modport source (output valid, output root, output frac_bits, input ready);
	modport sink (input valid, input root, input frac_bits, output ready);

endinterface

/* hw/rtl/integer_square_root_unit.sv */
// Two front stages for decode and normalize, then one stage per root bit.
// Throughput: one transaction per cycle while the response side is ready;
// each digit stage holds one compare and subtract.
// Ready runs back through the stage chain, so a stall halts only the full stages behind it.
// Reset clears all valid bits at once; the payload registers are not reset.
module integer_square_root_unit import isqrt_pkg::*; #(
	parameter int OPERAND_WIDTH = ISQRT_OPERAND_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	isqrt_req_if.sink   req,
	isqrt_rsp_if.source rsp
);

	localparam int W  = OPERAND_WIDTH;
	localparam int H  = W / 2;
	localparam int RW = 2 * W;

	// Chain links: index 0 leaves the front stages, index i+1 leaves digit step i.
	logic              valid_c [W+1];
	logic              ready_c [W+1];
	logic [RW-1:0]     rad_c   [W+1];
	logic [W+1:0]      rem_c   [W+1];
	logic [W-1:0]      root_c  [W+1];
	logic [FRAC_W-1:0] frac_c  [W+1];

	isqrt_prep #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.next_valid (valid_c[0]),
		.next_ready (ready_c[0]),
		.next_rad   (rad_c[0]),
		.next_frac  (frac_c[0])
	);

	// The digit recurrence starts from an empty remainder and root.
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	for (genvar i = 0; i < W; i++) begin : g_step
		isqrt_step #(
			.OPERAND_WIDTH(OPERAND_WIDTH)
		) u_step (
			.clk        (clk),
			.arst_n     (arst_n),
			.prev_valid (valid_c[i]),
			.prev_ready (ready_c[i]),
			.prev_rad   (rad_c[i]),
			.prev_rem   (rem_c[i]),
			.prev_root  (root_c[i]),
			.prev_frac  (frac_c[i]),
			.next_valid (valid_c[i+1]),
			.next_ready (ready_c[i+1]),
			.next_rad   (rad_c[i+1]),
			.next_rem   (rem_c[i+1]),
			.next_root  (root_c[i+1]),
			.next_frac  (frac_c[i+1])
		);
	end

	// The last digit stage is the output register.
	assign rsp.valid     = valid_c[W];
	assign ready_c[W]    = rsp.ready;
	assign rsp.root      = ROOT_W'(root_c[W]);
	assign rsp.frac_bits = frac_c[W];

	// Input stalls only when the whole chain ahead is full up to a waiting result.
	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp.valid)
		else $error("request channel stalled without a pending result");

	// The fraction-bit count is zero or at least half the operand width.
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.frac_bits == '0 || rsp.frac_bits >= FRAC_W'(H)))
		else $error("fraction-bit count out of range");

	// An integer root never exceeds half the operand width plus one bit.
	a_int_root_width: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.frac_bits == '0) |-> ((rsp.root >> (H + 1)) == '0))
		else $error("integer root too wide");

	// A normalized radicand yields a root with its upper bits populated.
	a_norm_root_msb: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.frac_bits > FRAC_W'(H)) |-> ((rsp.root >> (W - 2)) != '0))
		else $error("normalized root lost its leading bits");

endmodule

/* hw/rtl/isqrt_prep.sv */
// Two front stages: request decode with leading-zero count, then radicand build.
module isqrt_prep import isqrt_pkg::*; #(
	parameter int OPERAND_WIDTH = ISQRT_OPERAND_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	isqrt_req_if.sink                    req,
	output logic                         next_valid,
	input  logic                         next_ready,
	output logic [2*OPERAND_WIDTH-1:0]   next_rad,
	output logic [FRAC_W-1:0]            next_frac
);

	localparam int W  = OPERAND_WIDTH;
	localparam int H  = W / 2;
	localparam int RW = 2 * W;
	localparam int ZW = $clog2(W + 1);
	localparam int SW = ZW - 1;

	logic [W-1:0]      x;
	logic [ZW-1:0]     lz;
	logic [SW-1:0]     shift_n;
	logic              scaled_n;
	logic [FRAC_W-1:0] frac_n;

	logic              valid_s1;
	logic [W-1:0]      x_s1;
	logic [SW-1:0]     shift_s1;
	logic              scaled_s1;
	logic [FRAC_W-1:0] frac_s1;
	logic              ready_s1;

	logic [W-1:0]      y;
	logic [RW-1:0]     rad_n;

	logic              valid_s2;
	logic [RW-1:0]     rad_s2;
	logic [FRAC_W-1:0] frac_s2;
	logic              ready_s2;

	assign x = req.operand[W-1:0];

	// Leading-zero count: the highest set bit wins.
	always_comb begin
		lz = ZW'(W);
		for (int b = 0; b < W; b++) begin
			if (x[b]) begin
				lz = ZW'(W - 1 - b);
			end
		end
	end

	// Request decode: shift pairs, scaling and fraction-bit count.
	always_comb begin
		unique case (req.req_type)
			REQ_INT: begin
				shift_n  = '0;
				scaled_n = 1'b0;
				frac_n   = '0;
			end
			REQ_SCALED: begin
				shift_n  = '0;
				scaled_n = 1'b1;
				frac_n   = FRAC_W'(H);
			end
			default: begin
				// A zero operand is not normalized.
				shift_n  = (x == '0) ? '0 : lz[ZW-1:1];
				scaled_n = 1'b1;
				frac_n   = FRAC_W'(H) + FRAC_W'(shift_n);
			end
		endcase
	end

	// Backpressure: a stage takes data when it is empty or its successor moves.
	assign ready_s2  = ~valid_s2 | next_ready;
	assign ready_s1  = ~valid_s1 | ready_s2;
	assign req.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= req.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (req.valid && ready_s1) begin
			x_s1      <= x;
			shift_s1  <= shift_n;
			scaled_s1 <= scaled_n;
			frac_s1   <= frac_n;
		end
	end

	// Normalize by an even shift, then place the radicand for the root steps.
	always_comb begin
		y     = x_s1 << {shift_s1, 1'b0};
		rad_n = RW'(y);
		if (scaled_s1) begin
			rad_n = RW'(y) << (2 * H);
		end
	end

	// Stage two payload.
	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			rad_s2  <= rad_n;
			frac_s2 <= frac_s1;
		end
	end

	assign next_valid = valid_s2;
	assign next_rad   = rad_s2;
	assign next_frac  = frac_s2;

endmodule

/* hw/rtl/isqrt_step.sv */
// One restoring digit step of the root: shift in a bit pair, trial subtract.
module isqrt_step import isqrt_pkg::*; #(
	parameter int OPERAND_WIDTH = ISQRT_OPERAND_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         prev_valid,
	output logic                         prev_ready,
	input  logic [2*OPERAND_WIDTH-1:0]   prev_rad,
	input  logic [OPERAND_WIDTH+1:0]     prev_rem,
	input  logic [OPERAND_WIDTH-1:0]     prev_root,
	input  logic [FRAC_W-1:0]            prev_frac,
	output logic                         next_valid,
	input  logic                         next_ready,
	output logic [2*OPERAND_WIDTH-1:0]   next_rad,
	output logic [OPERAND_WIDTH+1:0]     next_rem,
	output logic [OPERAND_WIDTH-1:0]     next_root,
	output logic [FRAC_W-1:0]            next_frac
);

	localparam int W  = OPERAND_WIDTH;
	localparam int RW = 2 * W;

	logic [W+1:0]      cur;
	logic [W+1:0]      trial;
	logic [W+2:0]      diff;
	logic              fits;

	logic              valid_s1;
	logic [RW-1:0]     rad_s1;
	logic [W+1:0]      rem_s1;
	logic [W-1:0]      root_s1;
	logic [FRAC_W-1:0] frac_s1;

	// The remainder stays below 2^W, so its two top bits are zero here.
	always_comb begin
		cur   = {prev_rem[W-1:0], prev_rad[RW-1 -: 2]};
		trial = {prev_root, 2'b01};
		diff  = {1'b0, cur} - {1'b0, trial};
		fits  = ~diff[W+2];
	end

	assign prev_ready = ~valid_s1 | next_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (prev_ready) begin
			valid_s1 <= prev_valid;
		end
	end

	// Keep the difference when the trial fits and append the new root bit.
	always_ff @(posedge clk) begin
		if (prev_valid && prev_ready) begin
			rad_s1  <= {prev_rad[RW-3:0], 2'b00};
			rem_s1  <= fits ? diff[W+1:0] : cur;
			root_s1 <= {prev_root[W-2:0], fits};
			frac_s1 <= prev_frac;
		end
	end

	assign next_valid = valid_s1;
	assign next_rad   = rad_s1;
	assign next_rem   = rem_s1;
	assign next_root  = root_s1;
	assign next_frac  = frac_s1;

endmodule

/* test/isqrt_checker.sv */
`timescale 1ns / 1ps
// Checker for the square root unit: predicts every root and compares the responses in order.
module isqrt_checker import isqrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	isqrt_req_if req,
	isqrt_rsp_if rsp,
	output int   fail_count,
	output int   roots_pending
);

	localparam int HALF_W = ISQRT_OPERAND_WIDTH / 2;

	typedef struct packed {
		logic [ROOT_W-1:0] root;
		logic [FRAC_W-1:0] frac_bits;
	} root_result_t;

	root_result_t expected_roots [$];
	root_result_t want;
	int           mismatches = 0;

	// Restoring digit-by-digit root of a 128-bit radicand, one root bit per pass.
	function automatic logic [63:0] floor_root(input logic [127:0] radicand);
		logic [63:0]  q;
		logic [129:0] partial;
		logic [129:0] trial;
		q       = '0;
		partial = '0;
		for (int k = 63; k >= 0; k--) begin
			partial = {partial[127:0], radicand[2*k +: 2]};
			trial   = {64'b0, q, 2'b01};
			if (partial >= trial) begin
				partial = partial - trial;
				q       = {q[62:0], 1'b1};
			end else begin
				q = {q[62:0], 1'b0};
			end
		end
		return q;
	endfunction

	// Number of leading zeros of the operand within the operand width.
	function automatic int count_leading_zeros(input logic [OPERAND_W-1:0] x);
		int n;
		n = 0;
		for (int b = ISQRT_OPERAND_WIDTH - 1; b >= 0; b--) begin
			if (x[b])
				break;
			n++;
		end
		return n;
	endfunction

	// Expected root and fraction-bit count for one request.
	function automatic root_result_t predict_root(input logic [OPERAND_W-1:0] x,
			input logic [REQ_TYPE_W-1:0] kind);
		root_result_t         r;
		int                   shift_pairs;
		logic [OPERAND_W-1:0] normalized;
		if (kind == REQ_INT) begin
			r.root      = floor_root(128'(x));
			r.frac_bits = '0;
		end else if (kind == REQ_SCALED) begin
			r.root      = floor_root(128'(x) << (2 * HALF_W));
			r.frac_bits = FRAC_W'(HALF_W);
		end else if (x == '0) begin
			// A zero operand cannot be normalized; it keeps the plain scaling.
			r.root      = '0;
			r.frac_bits = FRAC_W'(HALF_W);
		end else begin
			// Any other code selects the normalized root: shift out pairs of leading zeros.
			shift_pairs = count_leading_zeros(x) / 2;
			normalized  = x << (2 * shift_pairs);
			r.root      = floor_root(128'(normalized) << (2 * HALF_W));
			r.frac_bits = FRAC_W'(HALF_W + shift_pairs);
		end
		return r;
	endfunction

	// Compare each response with the oldest prediction, then record new requests.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_roots.size() == 0) begin
					$error("Response with no outstanding request: root %h, frac_bits %0d",
						rsp.root, rsp.frac_bits);
					mismatches++;
				end else begin
					want = expected_roots.pop_front();
					if (rsp.root !== want.root) begin
						$error("root mismatch: expected %h, actual %h", want.root, rsp.root);
						mismatches++;
					end
					if (rsp.frac_bits !== want.frac_bits) begin
						$error("frac_bits mismatch: expected %0d, actual %0d",
							want.frac_bits, rsp.frac_bits);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_roots.push_back(predict_root(req.operand, req.req_type));
			fail_count    <= mismatches;
			roots_pending <= expected_roots.size();
		end
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Top of the square root unit testbench: clock, reset, request stimulus and the verdict.
module tb_top;
	import isqrt_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 80;
	localparam int PHASE_ITEMS    = 225;

	// The package names only two codes; both others select the normalized root.
	localparam logic [REQ_TYPE_W-1:0] REQ_NORM     = 2'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_NORM_ALT = 2'd3;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   idle_cycles = 0;
	int   fail_count;
	int   roots_pending;

	logic [REQ_TYPE_W-1:0] all_kinds [4] = '{REQ_INT, REQ_SCALED, REQ_NORM, REQ_NORM_ALT};
	logic [OPERAND_W-1:0]  corner_ops [14] = '{
		64'd1, 64'd2, 64'd3, 64'd4,
		64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
		64'h4000_0000_0000_0000, 64'h0000_0001_0000_0000,
		64'hFFFF_FFFE_0000_0001, 64'hFFFF_FFFE_0000_0000,
		64'h0000_0000_FFFF_FFFF, 64'h5555_5555_5555_5555,
		64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_0000_0010
	};

	isqrt_req_if req_ch ();
	isqrt_rsp_if rsp_ch ();

	integer_square_root_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	isqrt_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.fail_count    (fail_count),
		.roots_pending (roots_pending)
	);

	// Free-running clock with a 20 ns period.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Response side: held off during reset, then stalls at random at the rate of the phase.
	always @(posedge clk) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Present one request, with random idle cycles before it, and wait for its transaction.
	task automatic send_root_request(input logic [OPERAND_W-1:0] x,
			input logic [REQ_TYPE_W-1:0] kind);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid   <= 1'b0;
			req_ch.operand <= {$urandom, $urandom};
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.operand  <= x;
		req_ch.req_type <= kind;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Random operand drawn from several shapes so that every leading-zero count shows up.
	task automatic send_random_request();
		logic [OPERAND_W-1:0] x;
		logic [31:0]          r;
		case ($urandom_range(3))
			0: x = {$urandom, $urandom};
			1: x = {$urandom, $urandom} >> $urandom_range(63);
			2: begin
				// Perfect squares and their neighbors stress the last compare.
				r = $urandom;
				x = 64'(r) * 64'(r) + 64'($urandom_range(2)) - 64'd1;
			end
			default: x = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
		endcase
		send_root_request(x, all_kinds[$urandom_range(3)]);
	endtask

	initial begin
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.operand  <= '0;
		req_ch.req_type <= REQ_INT;
		send_idle_pct = 8;
		recv_idle_pct <= 46;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero and the full-range operand under every request code.
		for (int k = 0; k < 4; k++) begin
			send_root_request('0, all_kinds[k]);
			send_root_request('1, all_kinds[k]);
		end
		// Other corner operands, cycling through the codes.
		for (int i = 0; i < 14; i++)
			send_root_request(corner_ops[i], all_kinds[i % 4]);

		// Random phase with a slow receiver.
		repeat (PHASE_ITEMS) send_random_request();

		// Random phase with a slow sender.
		send_idle_pct = 46;
		recv_idle_pct <= 8;
		repeat (PHASE_ITEMS) send_random_request();

		// Random phase at full rate on both sides.
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		repeat (PHASE_ITEMS) send_random_request();

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (roots_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && roots_pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
